### rtl/cfr_pkg.sv
// ============================================================================
// cfr_pkg
// Types and constants shared by the camera frame reframer modules.
// ============================================================================
package cfr_pkg;

    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'h55;
    localparam logic [7:0] SOI_A  = 8'hFF;
    localparam logic [7:0] SOI_B  = 8'hD8;

    localparam logic [31:0] MIN_LEN_RESET = 32'd512;
    localparam logic [31:0] MAX_LEN_RESET = 32'd60000;
    localparam logic [31:0] MARKER_LEN    = 32'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MIN_LEN = 2'd0;
    localparam logic [1:0] REG_MAX_LEN = 2'd1;
    localparam logic [1:0] REG_CHAN_ID = 2'd2;

    // Position of the last byte of the outgoing header burst.
    localparam logic [3:0] HDR_LAST_IDX = 4'd8;

    typedef struct packed {
        logic [31:0] min_len;
        logic [31:0] max_len;
        logic [7:0]  chan_id;
    } cfr_cfg_t;

    // One decoded input transaction as seen by the emitter.
    typedef struct packed {
        logic        hdr;      // D8 accepted: emit the header burst
        logic        body;     // body byte to forward
        logic [7:0]  data;
        logic        last;     // final body byte of the frame
        logic [31:0] length;
    } cfr_evt_t;

endpackage

### rtl/cfr_regs.sv
// ============================================================================
// cfr_regs
// Configuration registers: frame length limits and channel identity.
// ============================================================================
module cfr_regs
    import cfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfr_cfg_t    cfg
);

    cfr_cfg_t cfg_reg;
    cfr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_LEN: cfg_next.min_len = cfg_data;
                REG_MAX_LEN: cfg_next.max_len = cfg_data;
                REG_CHAN_ID: cfg_next.chan_id = cfg_data[7:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_len <= MIN_LEN_RESET;
            cfg_reg.max_len <= MAX_LEN_RESET;
            cfg_reg.chan_id <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/cfr_parser.sv
// ============================================================================
// cfr_parser
// Input framing parser: sync hunt, length capture and body marker check.
// ============================================================================
module cfr_parser
    import cfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  cfr_cfg_t   cfg,
    output cfr_evt_t   evt
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_SYNC = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] bcnt_reg, bcnt_next;

    logic [31:0] len_shift;
    logic [31:0] bcnt_inc;
    logic        len_ok;

    assign len_shift = {rx_byte, len_reg[31:8]};
    assign bcnt_inc  = bcnt_reg + 32'd1;
    assign len_ok    = (len_shift >= MARKER_LEN) && (len_shift >= cfg.min_len) &&
                       (len_shift < cfg.max_len);

    always_comb
    begin
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        len_next   = len_reg;
        bcnt_next  = bcnt_reg;
        evt        = '0;
        evt.data   = rx_byte;
        evt.length = len_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    phase_next = (rx_byte == SYNC_A) ? PH_SYNC : PH_HUNT;
                end
                PH_SYNC:
                begin
                    if (rx_byte == SYNC_B)
                    begin
                        phase_next = PH_LEN;
                        hcnt_next  = 2'd0;
                        len_next   = 32'd0;
                    end
                    else
                    begin
                        phase_next = (rx_byte == SYNC_A) ? PH_SYNC : PH_HUNT;
                    end
                end
                PH_LEN:
                begin
                    len_next  = len_shift;
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_reg == 2'd3)
                    begin
                        bcnt_next  = 32'd0;
                        phase_next = len_ok ? PH_BODY : PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    if (bcnt_reg == 32'd0)
                    begin
                        if (rx_byte != SOI_A)
                            phase_next = PH_HUNT;
                        else
                            bcnt_next = 32'd1;
                    end
                    else if (bcnt_reg == 32'd1)
                    begin
                        if (rx_byte != SOI_B)
                        begin
                            phase_next = PH_HUNT;
                        end
                        else
                        begin
                            bcnt_next = MARKER_LEN;
                            evt.hdr   = 1'b1;
                            // A body of exactly the marker ends on the D8.
                            evt.last  = (len_reg <= MARKER_LEN);
                            if (len_reg <= MARKER_LEN)
                                phase_next = PH_HUNT;
                        end
                    end
                    else
                    begin
                        bcnt_next = bcnt_inc;
                        evt.body  = 1'b1;
                        evt.last  = (bcnt_inc >= len_reg);
                        if (bcnt_inc >= len_reg)
                            phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            hcnt_reg  <= 2'd0;
            len_reg   <= 32'd0;
            bcnt_reg  <= 32'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            len_reg   <= len_next;
            bcnt_reg  <= bcnt_next;
        end
    end

endmodule

### rtl/cfr_emit.sv
// ============================================================================
// cfr_emit
// Output stage: result register and the nine-byte header burst sequencer.
// ============================================================================
module cfr_emit
    import cfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       evt_accept,
    input  cfr_evt_t   evt,
    input  logic [7:0] chan_id,
    output logic       busy,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       frame_last
);

    logic        valid_reg, valid_next;
    logic        burst_reg, burst_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [31:0] hlen_reg, hlen_next;
    logic [7:0]  hchan_reg, hchan_next;
    logic        hlast_reg, hlast_next;

    logic       slot_free;
    logic [7:0] burst_byte;

    assign slot_free = !valid_reg || !out_stall;
    assign busy      = burst_reg || (valid_reg && out_stall);

    always_comb
    begin
        case (idx_reg)
            4'd0:    burst_byte = SYNC_A;
            4'd1:    burst_byte = SYNC_B;
            4'd2:    burst_byte = hchan_reg;
            4'd3:    burst_byte = hlen_reg[7:0];
            4'd4:    burst_byte = hlen_reg[15:8];
            4'd5:    burst_byte = hlen_reg[23:16];
            4'd6:    burst_byte = hlen_reg[31:24];
            4'd7:    burst_byte = SOI_A;
            4'd8:    burst_byte = SOI_B;
            default: burst_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        burst_next = burst_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        hlen_next  = hlen_reg;
        hchan_next = hchan_reg;
        hlast_next = hlast_reg;
        if (slot_free)
        begin
            if (burst_reg)
            begin
                valid_next = 1'b1;
                byte_next  = burst_byte;
                last_next  = (idx_reg == HDR_LAST_IDX) && hlast_reg;
                idx_next   = idx_reg + 4'd1;
                if (idx_reg == HDR_LAST_IDX)
                    burst_next = 1'b0;
            end
            else if (evt_accept && evt.hdr)
            begin
                valid_next = 1'b1;
                burst_next = 1'b1;
                idx_next   = 4'd1;
                byte_next  = SYNC_A;
                last_next  = 1'b0;
                hlen_next  = evt.length;
                hchan_next = chan_id;
                hlast_next = evt.last;
            end
            else if (evt_accept && evt.body)
            begin
                valid_next = 1'b1;
                byte_next  = evt.data;
                last_next  = evt.last;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            burst_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            burst_reg <= burst_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        hlen_reg  <= hlen_next;
        hchan_reg <= hchan_next;
        hlast_reg <= hlast_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign frame_last = last_reg;

    // A header burst always has a byte on show.
    a_burst_valid: assert property (@(posedge clk) disable iff (!rst_n)
        burst_reg |-> valid_reg)
        else $error("header burst without a valid output byte");

    a_burst_idx: assert property (@(posedge clk) disable iff (!rst_n)
        burst_reg |-> (idx_reg >= 4'd1 && idx_reg <= HDR_LAST_IDX))
        else $error("header burst index out of range");

    a_hdr_start: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_accept && evt.hdr) |=> (valid_reg && burst_reg && byte_reg == SYNC_A))
        else $error("header burst did not start with the sync byte");

endmodule

### rtl/camera_frame_reframer_unit.sv
// ============================================================================
// camera_frame_reframer_unit
// Reframes a camera byte stream: checks length and JPEG marker, then emits
// a new header with the channel id and forwards the body bytes.
// ============================================================================
//
//  Channel   Handshake             Payload
//  input     in_valid / in_stall   rx_byte[7:0]
//  output    out_valid / out_stall out_byte[7:0], frame_last
//  config    cfg_we                cfg_index[1:0], cfg_data[31:0]
//
//  An input transaction is decoded in the cycle it is accepted and its result
//  appears in the output register on the next cycle; one byte per cycle is
//  sustained while the output side takes its transactions and no burst runs.
//  The D8 that opens a frame starts a nine-byte header burst from the output
//  register, and in_stall stays high while it runs.
//  in_stall is also high while a result waits under out_stall.
//  Reset clears the parser, the output register and restores register defaults.
//
module camera_frame_reframer_unit
    import cfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_last
);

    cfr_cfg_t cfg;
    cfr_evt_t evt;
    logic     busy;
    logic     in_accept;

    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;

    cfr_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .rx_byte (rx_byte),
        .cfg     (cfg),
        .evt     (evt)
    );

    cfr_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_accept (in_accept),
        .evt        (evt),
        .chan_id    (cfg.chan_id),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .frame_last (frame_last)
    );

endmodule

### tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for camera_frame_reframer_unit. Camera byte streams made
// of well-formed frames, broken frames and noise are sent in random bursts
// while the receiver stalls on its own pattern. A scoreboard predicts every
// re-framed output byte and compares it with what the block delivers.
// ============================================================================
module tb_top;
    import cfr_pkg::*;

    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          IDLE_LIMIT    = 4000;
    localparam int          TOTAL_ITEMS   = 480;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;

    typedef enum logic [1:0] {PS_HUNT, PS_SYNC, PS_LENGTH, PS_BODY} parse_state_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // Predicts the outgoing stream from the accepted camera bytes.
    class frame_scoreboard;
        cfr_cfg_t     cfg;
        parse_state_e state;
        logic [1:0]   len_idx;
        logic [31:0]  len_acc;
        logic [31:0]  body_seen;
        out_beat_t    expected[$];
        int unsigned  mismatches;
        int unsigned  frames_opened;
        int unsigned  bytes_checked;

        function new();
            cfg.min_len   = MIN_LEN_RESET;
            cfg.max_len   = MAX_LEN_RESET;
            cfg.chan_id   = 8'h00;
            state         = PS_HUNT;
            len_idx       = 2'd0;
            len_acc       = 32'd0;
            body_seen     = 32'd0;
            mismatches    = 0;
            frames_opened = 0;
            bytes_checked = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_MIN_LEN: cfg.min_len = data;
                REG_MAX_LEN: cfg.max_len = data;
                REG_CHAN_ID: cfg.chan_id = data[7:0];
                default: ;
            endcase
        endfunction

        function void push_beat(logic [7:0] data, logic last);
            out_beat_t beat;
            beat.data = data;
            beat.last = last;
            expected.push_back(beat);
        endfunction

        function void note_input(logic [7:0] b);
            logic done;
            case (state)
                PS_HUNT: state = (b == SYNC_A) ? PS_SYNC : PS_HUNT;
                PS_SYNC:
                begin
                    if (b == SYNC_B)
                    begin
                        state   = PS_LENGTH;
                        len_idx = 2'd0;
                        len_acc = 32'd0;
                    end
                    else
                    begin
                        state = (b == SYNC_A) ? PS_SYNC : PS_HUNT;
                    end
                end
                PS_LENGTH:
                begin
                    len_acc = {b, len_acc[31:8]};
                    if (len_idx == 2'd3)
                    begin
                        len_idx   = 2'd0;
                        body_seen = 32'd0;
                        if (len_acc >= MARKER_LEN && len_acc >= cfg.min_len &&
                            len_acc < cfg.max_len)
                            state = PS_BODY;
                        else
                            state = PS_HUNT;
                    end
                    else
                    begin
                        len_idx = len_idx + 2'd1;
                    end
                end
                default:
                begin
                    if (body_seen == 32'd0)
                    begin
                        if (b != SOI_A)
                            state = PS_HUNT;
                        else
                            body_seen = 32'd1;
                    end
                    else if (body_seen == 32'd1)
                    begin
                        if (b != SOI_B)
                        begin
                            state = PS_HUNT;
                        end
                        else
                        begin
                            body_seen = 32'd2;
                            done      = (body_seen >= len_acc);
                            push_beat(SYNC_A, 1'b0);
                            push_beat(SYNC_B, 1'b0);
                            push_beat(cfg.chan_id, 1'b0);
                            push_beat(len_acc[7:0], 1'b0);
                            push_beat(len_acc[15:8], 1'b0);
                            push_beat(len_acc[23:16], 1'b0);
                            push_beat(len_acc[31:24], 1'b0);
                            push_beat(SOI_A, 1'b0);
                            push_beat(SOI_B, done);
                            frames_opened++;
                            if (done)
                                state = PS_HUNT;
                        end
                    end
                    else
                    begin
                        body_seen = body_seen + 32'd1;
                        done      = (body_seen >= len_acc);
                        push_beat(b, done);
                        if (done)
                            state = PS_HUNT;
                    end
                end
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 30)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(logic [7:0] data, logic last);
            out_beat_t beat;
            if (expected.size() == 0)
            begin
                report($sformatf("output byte %02h with nothing expected", data));
                return;
            end
            beat = expected.pop_front();
            bytes_checked++;
            if (data !== beat.data)
                report($sformatf("out_byte %02h, expected %02h", data, beat.data));
            if (last !== beat.last)
                report($sformatf("frame_last %0b on byte %02h, expected %0b",
                                 last, data, beat.last));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data  = 32'd0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        frame_last;

    frame_scoreboard sb;
    int          idle_cycles  = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;
    int          settings_run = 0;
    bit          hold_request = 1'b0;

    camera_frame_reframer_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .frame_last (frame_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Both channels are sampled here, input first, so that expectations are
    // always queued before the results they describe can be accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(rx_byte);
            if (out_valid && !out_stall)
                sb.check_result(out_byte, frame_last);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("no transaction for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : receiver
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Offers one byte and returns at the edge where the transaction happens.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_header(input logic [31:0] len);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        for (int i = 0; i < 4; i++)
            send_byte(len[8*i +: 8]);
    endtask

    task automatic send_body(input logic [31:0] len);
        send_byte(SOI_A);
        send_byte(SOI_B);
        for (longint i = 2; i < longint'(len); i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] min_len, input logic [31:0] max_len,
                            input logic [7:0] chan);
        logic [31:0] chan_word;
        logic [31:0] junk;
        chan_word = {24'($urandom()), chan};
        junk      = $urandom();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_LEN;
        cfg_data  <= min_len;
        @(posedge clk);
        sb.write_reg(REG_MIN_LEN, min_len);
        cfg_index <= REG_MAX_LEN;
        cfg_data  <= max_len;
        @(posedge clk);
        sb.write_reg(REG_MAX_LEN, max_len);
        cfg_index <= REG_CHAN_ID;
        cfg_data  <= chan_word;
        @(posedge clk);
        sb.write_reg(REG_CHAN_ID, chan_word);
        cfg_index <= REG_UNUSED;
        cfg_data  <= junk;
        @(posedge clk);
        sb.write_reg(REG_UNUSED, junk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    initial
    begin : stimulus
        int          target;
        int          frames_left;
        int          frames_sent;
        int          kind;
        int          count;
        longint      lo;
        longint      hi;
        logic [31:0] len;
        logic [31:0] new_min;
        logic [31:0] new_max;
        logic [7:0]  chan;

        sb          = new();
        frames_left = 0;
        frames_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default limits straight after reset: 511 is too short and 60000 is
        // too long, so neither marker opens a frame.
        send_header(MIN_LEN_RESET - 32'd1);
        send_byte(SOI_A);
        send_byte(SOI_B);
        send_header(MAX_LEN_RESET);
        send_byte(SOI_A);
        send_byte(SOI_B);

        wait_idle();
        set_regs(32'd0, 32'd4, 8'hFF);
        send_byte(8'h00);
        send_byte(SYNC_A);
        send_byte(8'h13);
        // AA AA 55 keeps the sync, and a two-byte body ends on the D8.
        send_byte(SYNC_A);
        send_header(32'd2);
        send_byte(SOI_A);
        send_byte(SOI_B);
        send_header(32'd1);
        send_header(32'd0);
        send_header(32'd3);
        send_byte(8'hFE);
        send_header(32'd3);
        send_byte(SOI_A);
        send_byte(8'hD9);
        send_header(32'd3);
        send_body(32'd3);
        send_header(32'd4);
        send_header(32'hFFFF_FFFF);

        // Limits and channel changed while the length is half collected.
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(8'h05);
        send_byte(8'h00);
        wait_idle();
        set_regs(32'd5, 32'd6, 8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_body(32'd5);

        wait_idle();
        set_regs(32'hFFFF_FFFF, 32'd0, 8'h5A);
        send_header(32'd2);
        send_body(32'd2);

        target = TOTAL_ITEMS;
        while (items_sent < target)
        begin
            if (frames_left == 0)
            begin
                wait_idle();
                case ($urandom_range(0, 4))
                    0:
                    begin
                        new_min = 32'd0;
                        new_max = 32'd64;
                    end
                    1:
                    begin
                        new_min = $urandom_range(2, 12);
                        new_max = $urandom_range(13, 40);
                    end
                    2:
                    begin
                        new_min = 32'd20;
                        new_max = 32'd10;
                    end
                    3:
                    begin
                        new_min = 32'd0;
                        new_max = 32'hFFFF_FFFF;
                    end
                    default:
                    begin
                        new_min = $urandom_range(0, 3);
                        new_max = $urandom_range(0, 4);
                    end
                endcase
                case ($urandom_range(0, 3))
                    0:       chan = 8'h00;
                    1:       chan = 8'hFF;
                    default: chan = 8'($urandom_range(0, 255));
                endcase
                set_regs(new_min, new_max, chan);
                frames_left = $urandom_range(4, 10);
            end
            frames_left--;
            frames_sent++;
            // Long receiver hold-off while bytes keep coming.
            if (frames_sent == 25)
                hold_request = 1'b1;

            lo = (sb.cfg.min_len < 32'd2) ? 2 : longint'(sb.cfg.min_len);
            hi = (sb.cfg.max_len > 32'd49) ? 48 : longint'(sb.cfg.max_len) - 1;
            if (lo <= hi && $urandom_range(0, 4) != 0)
                len = $urandom_range(int'(lo), int'(hi));
            else
                len = $urandom_range(0, 50);

            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                send_header(len);
                send_body(len);
            end
            else if (kind < 75)
            begin
                send_header(len);
                if ($urandom_range(0, 1) == 0)
                begin
                    send_byte(8'($urandom_range(0, 254)));
                end
                else
                begin
                    send_byte(SOI_A);
                    chan = 8'($urandom_range(0, 255));
                    send_byte((chan == SOI_B) ? 8'h00 : chan);
                end
            end
            else if (kind < 85)
            begin
                count = $urandom_range(1, 10);
                repeat (count)
                    send_byte(($urandom_range(0, 3) == 0) ? SYNC_A
                                                         : 8'($urandom_range(0, 255)));
            end
            else if (kind < 93)
            begin
                if (sb.cfg.max_len <= 32'd1000)
                    send_header($urandom() | 32'h0000_0400);
                else
                    send_header(sb.cfg.max_len);
                send_body(32'd4);
            end
            else
            begin
                // A header cut short, then a full frame whose leading bytes the parser
                // swallows as length bytes.
                send_byte(SYNC_A);
                send_byte(SYNC_B);
                count = $urandom_range(0, 3);
                repeat (count)
                    send_byte(8'($urandom_range(0, 255)));
                send_header(len);
                send_body(len);
            end
        end

        wait_idle();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected bytes never arrived", sb.pending()));
        $display("sent %0d camera bytes under %0d register settings", items_sent,
                 settings_run);
        $display("re-framed %0d frames, checked %0d output bytes", sb.frames_opened,
                 sb.bytes_checked);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/cfr_pkg.sv
rtl/cfr_regs.sv
rtl/cfr_parser.sv
rtl/cfr_emit.sv
rtl/camera_frame_reframer_unit.sv
tb/tb_top.sv
